// ===== rtl/ftre_pkg.sv =====
// shared types and constants for the frame timestamp rollover extender
`timescale 1ns / 1ps
`default_nettype none
package ftre_pkg;

  localparam int DATA_W        = 64;
  localparam int FREQ_W        = 30;
  localparam int RTT_W         = 32;
  localparam int PROD_W        = DATA_W + FREQ_W;
  localparam int CNT_W         = $clog2(PROD_W);
  localparam int MBIT_W        = $clog2(FREQ_W);
  localparam int CFG_IDX_W     = 2;
  localparam int WRAP_BITS_DEF = 32;

  localparam logic [FREQ_W-1:0] DEVICE_HZ_RESET = FREQ_W'(1000);
  localparam logic [FREQ_W-1:0] FRAME_HZ_RESET  = FREQ_W'(1000000);
  localparam logic [FREQ_W-1:0] MS_PER_S        = FREQ_W'(1000);
  localparam logic [FREQ_W-1:0] US_PER_S        = FREQ_W'(1000000);
  localparam logic [DATA_W-1:0] NEAR_START_MS   = DATA_W'(50);

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_HZ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HZ  = CFG_IDX_W'(1);

  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    OP_MAG   = 2'd0,
    OP_PREV  = 2'd1,
    OP_BASE  = 2'd2,
    OP_STAMP = 2'd3
  } op_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic start;
    op_t  op;
    logic take_mag;
    logic take_prev;
    logic take_diff;
    logic take_renew;
    logic take_base;
    logic commit;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic renew;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/ftre_muldiv.sv =====
// serial multiply then restoring divide: q = sat64(floor(x * m / d))
`timescale 1ns / 1ps
`default_nettype none
module ftre_muldiv (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ftre_pkg::DATA_W-1:0] x,
  input  wire logic [ftre_pkg::FREQ_W-1:0] m,
  input  wire logic [ftre_pkg::FREQ_W-1:0] d,
  output logic                            done,
  output logic [ftre_pkg::DATA_W-1:0]      q
);
  import ftre_pkg::*;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  md_state_t         state;
  logic [PROD_W-1:0] acc;
  logic [FREQ_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] xr;
  logic [FREQ_W-1:0] mr;
  logic [FREQ_W-1:0] dr;
  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   trial_sub;
  logic              ge;

  assign trial     = {rem, acc[PROD_W-1]};
  assign trial_sub = trial - {1'b0, dr};
  assign ge        = trial >= {1'b0, dr};
  assign q         = (|acc[PROD_W-1:DATA_W]) ? '1 : acc[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        MD_IDLE: begin
          if (start) begin
            state <= MD_MUL;
          end
        end
        MD_MUL: begin
          if (cnt == '0) begin
            state <= MD_DIV;
          end
        end
        MD_DIV: begin
          if (cnt == '0) begin
            state <= MD_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MD_IDLE: begin
        if (start) begin
          xr  <= x;
          mr  <= m;
          dr  <= d;
          acc <= '0;
          cnt <= CNT_W'(FREQ_W - 1);
        end
      end
      MD_MUL: begin
        // msb-first shift and add
        acc <= {acc[PROD_W-2:0], 1'b0}
             + (mr[cnt[MBIT_W-1:0]] ? {{FREQ_W{1'b0}}, xr} : '0);
        if (cnt == '0) begin
          cnt <= CNT_W'(PROD_W - 1);
          rem <= '0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      MD_DIV: begin
        rem <= ge ? trial_sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
        acc <= {acc[PROD_W-2:0], ge};
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/ftre_datapath.sv =====
// state, operand selection, decision logic and output register
`timescale 1ns / 1ps
`default_nettype none
module ftre_datapath #(
  parameter int WRAP_BITS = ftre_pkg::WRAP_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ftre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ftre_pkg::FREQ_W-1:0]    cfg_data,
  input  wire logic [ftre_pkg::DATA_W-1:0]    raw_ticks,
  input  wire logic [ftre_pkg::DATA_W-1:0]    host_ms,
  input  wire logic [ftre_pkg::DATA_W-1:0]    device_time,
  input  wire logic [ftre_pkg::RTT_W-1:0]     round_trip,
  input  wire ftre_pkg::cmd_t                 cmd,
  output ftre_pkg::stat_t                     stat,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic [ftre_pkg::DATA_W-1:0]         stamp_us,
  output logic                               base_renewed
);
  import ftre_pkg::*;

  localparam logic [DATA_W-1:0] WRAP     = DATA_W'(1) << WRAP_BITS;
  localparam logic [DATA_W-1:0] LOW_MASK = WRAP - DATA_W'(1);

  logic [FREQ_W-1:0] dev_hz;
  logic [FREQ_W-1:0] frm_hz;
  logic [FREQ_W-1:0] fhz;
  logic [FREQ_W-1:0] dhz;

  logic [DATA_W-1:0] prev_raw;
  logic [DATA_W-1:0] prev_host;
  logic [DATA_W-1:0] base;

  logic [DATA_W-1:0] cur_raw;
  logic [DATA_W-1:0] cur_host;
  logic [DATA_W-1:0] sum;
  logic              dec;
  logic [DATA_W-1:0] mag;
  logic [DATA_W-1:0] host_d;
  logic [DATA_W-1:0] src_ms;
  logic [DATA_W-1:0] prev_ms;
  logic [DATA_W:0]   diff;
  logic              renewed;

  logic [DATA_W-1:0] md_x;
  logic [FREQ_W-1:0] md_m;
  logic [FREQ_W-1:0] md_d;
  logic              md_done;
  logic [DATA_W-1:0] md_q;

  logic [DATA_W-1:0] half_rtt;
  logic [DATA_W:0]   sum_wide;
  logic [DATA_W-1:0] mag_sat;
  logic [DATA_W-1:0] ticks;
  logic              ahead;
  logic [DATA_W-1:0] base_next;

  assign fhz = (frm_hz == '0) ? FREQ_W'(1) : frm_hz;
  assign dhz = (dev_hz == '0) ? FREQ_W'(1) : dev_hz;

  assign half_rtt = DATA_W'(round_trip >> 1);
  assign sum_wide = {1'b0, device_time} + {1'b0, half_rtt};
  assign mag_sat  = md_q[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : md_q;
  assign ticks    = (base & ~LOW_MASK) | (cur_raw & LOW_MASK);
  assign ahead    = !diff[DATA_W] && (diff[DATA_W-1:0] >= {1'b0, prev_ms[DATA_W-1:1]});

  // drop back one wrap when the base's low part is not above the raw value and the base exceeds one wrap
  assign base_next = ((md_q & LOW_MASK) <= cur_raw && md_q > WRAP) ? md_q - WRAP : md_q;

  always_comb begin
    unique case (cmd.op)
      OP_MAG:   begin md_x = mag;      md_m = MS_PER_S; md_d = fhz; end
      OP_PREV:  begin md_x = prev_raw; md_m = MS_PER_S; md_d = fhz; end
      OP_BASE:  begin md_x = sum;      md_m = fhz;      md_d = dhz; end
      OP_STAMP: begin md_x = ticks;    md_m = US_PER_S; md_d = fhz; end
      default:  begin md_x = mag;      md_m = MS_PER_S; md_d = fhz; end
    endcase
  end

  ftre_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start),
    .x     (md_x),
    .m     (md_m),
    .d     (md_d),
    .done  (md_done),
    .q     (md_q)
  );

  assign stat.done     = md_done;
  assign stat.renew    = (base == '0)
                       || ((dec || ahead) && (cur_raw != '0 || prev_raw != '0))
                       || (prev_ms <= NEAR_START_MS);
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_hz    <= DEVICE_HZ_RESET;
      frm_hz    <= FRAME_HZ_RESET;
      prev_raw  <= '0;
      prev_host <= '0;
      base      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_DEVICE_HZ) begin
        dev_hz <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_FRAME_HZ) begin
        frm_hz <= cfg_data;
      end
      if (cmd.clear) begin
        prev_raw  <= '0;
        prev_host <= '0;
        base      <= '0;
      end
      if (cmd.take_base) begin
        base <= base_next;
      end
      if (cmd.commit) begin
        prev_raw  <= cur_raw;
        prev_host <= cur_host;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_raw  <= raw_ticks;
      cur_host <= host_ms;
      dec      <= raw_ticks < prev_raw;
      mag      <= (raw_ticks < prev_raw) ? prev_raw - raw_ticks : raw_ticks - prev_raw;
      host_d   <= host_ms - prev_host;
      sum      <= sum_wide[DATA_W] ? '1 : sum_wide[DATA_W-1:0];
    end
    if (cmd.take_mag) begin
      src_ms <= dec ? -mag_sat : mag_sat;
    end
    if (cmd.take_prev) begin
      prev_ms <= md_q;
    end
    if (cmd.take_diff) begin
      diff <= {host_d[DATA_W-1], host_d} - {src_ms[DATA_W-1], src_ms};
    end
    if (cmd.take_renew) begin
      renewed <= stat.renew;
    end
    if (cmd.push) begin
      stamp_us     <= md_q;
      base_renewed <= renewed;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ftre_ctrl.sv =====
// sequencer for one frame item: conversions, decision, result hand-off
`timescale 1ns / 1ps
`default_nettype none
module ftre_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            mode,
  output logic                 in_stall,
  input  wire ftre_pkg::stat_t stat,
  output ftre_pkg::cmd_t       cmd
);
  import ftre_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE       = 12'b000000000001,
    S_MAG_GO     = 12'b000000000010,
    S_MAG_WAIT   = 12'b000000000100,
    S_PREV_GO    = 12'b000000001000,
    S_PREV_WAIT  = 12'b000000010000,
    S_DIFF       = 12'b000000100000,
    S_EVAL       = 12'b000001000000,
    S_BASE_GO    = 12'b000010000000,
    S_BASE_WAIT  = 12'b000100000000,
    S_STAMP_GO   = 12'b001000000000,
    S_STAMP_WAIT = 12'b010000000000,
    S_PUSH       = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_MAG;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = S_MAG_GO;
          end
        end
      end
      S_MAG_GO: begin
        cmd.start  = 1'b1;
        state_next = S_MAG_WAIT;
      end
      S_MAG_WAIT: begin
        if (stat.done) begin
          cmd.take_mag = 1'b1;
          state_next   = S_PREV_GO;
        end
      end
      S_PREV_GO: begin
        cmd.op     = OP_PREV;
        cmd.start  = 1'b1;
        state_next = S_PREV_WAIT;
      end
      S_PREV_WAIT: begin
        if (stat.done) begin
          cmd.take_prev = 1'b1;
          state_next    = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.take_diff = 1'b1;
        state_next    = S_EVAL;
      end
      S_EVAL: begin
        cmd.take_renew = 1'b1;
        state_next     = stat.renew ? S_BASE_GO : S_STAMP_GO;
      end
      S_BASE_GO: begin
        cmd.op     = OP_BASE;
        cmd.start  = 1'b1;
        state_next = S_BASE_WAIT;
      end
      S_BASE_WAIT: begin
        cmd.op = OP_BASE;
        if (stat.done) begin
          cmd.take_base = 1'b1;
          state_next    = S_STAMP_GO;
        end
      end
      S_STAMP_GO: begin
        cmd.op     = OP_STAMP;
        cmd.start  = 1'b1;
        cmd.commit = 1'b1;
        state_next = S_STAMP_WAIT;
      end
      S_STAMP_WAIT: begin
        cmd.op = OP_STAMP;
        if (stat.done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        // wait for the output register to free up
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/frame_timestamp_rollover_extend.sv =====
// top level of the frame timestamp rollover extender
//
//   channel  direction  handshake           payload
//   cfg      in         cfg_we              cfg_index, cfg_data
//   in       in         in_valid, in_stall  mode, raw_ticks, host_ms, device_time, round_trip
//   out      out        out_valid, out_stall stamp_us, base_renewed
//
// a frame item runs three conversions on one shared serial multiply-divide unit, or four
// when the base is renewed; each takes 30 multiply steps plus 94 divide steps.
// a clear item is taken while the block stays idle and gives no result.
// synchronous reset restores the clock registers and zeroes the kept previous values and base.
// a stalled result sits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module frame_timestamp_rollover_extend #(
  parameter int WRAP_BITS = ftre_pkg::WRAP_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ftre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ftre_pkg::FREQ_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic [ftre_pkg::DATA_W-1:0]    raw_ticks,
  input  wire logic [ftre_pkg::DATA_W-1:0]    host_ms,
  input  wire logic [ftre_pkg::DATA_W-1:0]    device_time,
  input  wire logic [ftre_pkg::RTT_W-1:0]     round_trip,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ftre_pkg::DATA_W-1:0]         stamp_us,
  output logic                               base_renewed
);
  import ftre_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ftre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ftre_datapath #(
    .WRAP_BITS (WRAP_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .raw_ticks    (raw_ticks),
    .host_ms      (host_ms),
    .device_time  (device_time),
    .round_trip   (round_trip),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .stamp_us     (stamp_us),
    .base_renewed (base_renewed)
  );

endmodule
`default_nettype wire

// ===== rtl/ftre_checker.sv =====
// port-level checks for the frame timestamp rollover extender
`timescale 1ns / 1ps
`default_nettype none
module ftre_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       mode,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [ftre_pkg::DATA_W-1:0] stamp_us,
  input wire logic                       base_renewed
);
  import ftre_pkg::*;

  // a frame transfer starts work, so the input stalls next cycle
  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode != MODE_CLEAR) |=> in_stall)
    else $error("input not stalled after frame transfer");

  // a clear item leaves the block idle
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == MODE_CLEAR) |=> !in_stall)
    else $error("input stalled after clear transfer");

  // reset leaves the block idle with no pending result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!in_stall && !out_valid))
    else $error("block not idle after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(stamp_us) && $stable(base_renewed)))
    else $error("stalled result changed");

endmodule

bind frame_timestamp_rollover_extend ftre_checker u_ftre_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .mode         (mode),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .stamp_us     (stamp_us),
  .base_renewed (base_renewed)
);
`default_nettype wire
